// File: rtl/bwms_pkg.sv
// ----------------------------------------------------------------------------
// bwms_pkg
// Shared types and constants of the button wave mode selector.
// ----------------------------------------------------------------------------
package bwms_pkg;

  localparam int unsigned CfgAddrW = 4;

  localparam logic [7:0] SampleIntervalRst = 8'd20;
  localparam logic [7:0] AutoPeriodRst     = 8'd250;
  localparam logic [7:0] LongPressRst      = 8'd50;

  localparam logic [7:0] CountMax = 8'd255;

  // Bit positions of the two-bit key code
  localparam int unsigned KeyOneBit = 0;
  localparam int unsigned KeyTwoBit = 1;

  // Register indexes (byte address divided by four)
  typedef enum logic [1:0] {
    RegSampleInterval = 2'd0,
    RegAutoPeriod     = 2'd1,
    RegLongPress      = 2'd2,
    RegNone           = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] sample_interval;
    logic [7:0] auto_period;
    logic [7:0] long_press;
  } cfg_t;

  typedef struct packed {
    logic       pin_a;
    logic       pin_b;
    logic       pin_c;
    logic [1:0] wave_mode;
    logic       auto_on;
  } result_t;

endpackage

// File: rtl/bwms_regs.sv
// ----------------------------------------------------------------------------
// bwms_regs
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module bwms_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bwms_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output bwms_pkg::cfg_t                 cfg_o
);
  import bwms_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[CfgAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_interval <= SampleIntervalRst;
      cfg_q.auto_period     <= AutoPeriodRst;
      cfg_q.long_press      <= LongPressRst;
    end else if (wr_en) begin
      case (idx)
        RegSampleInterval: cfg_q.sample_interval <= pwdata[7:0];
        RegAutoPeriod:     cfg_q.auto_period     <= pwdata[7:0];
        RegLongPress:      cfg_q.long_press      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegSampleInterval: prdata = {24'd0, cfg_q.sample_interval};
      RegAutoPeriod:     prdata = {24'd0, cfg_q.auto_period};
      RegLongPress:      prdata = {24'd0, cfg_q.long_press};
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/bwms_core.sv
// ----------------------------------------------------------------------------
// bwms_core
// Per-tick sampling, debounce, press timing and mode update.
// ----------------------------------------------------------------------------
module bwms_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bwms_pkg::cfg_t    cfg_i,
  input  logic              tick_i,
  input  logic              key_one_raw_i,
  input  logic              key_two_raw_i,
  output bwms_pkg::result_t res_o
);
  import bwms_pkg::*;

  logic [7:0] elapsed_q, elapsed_d;
  logic [1:0] last_q, last_d;
  logic [1:0] deb_q, deb_d;
  logic [1:0] prev_q, prev_d;
  logic [7:0] scount_q, scount_d;
  logic       pflag_q, pflag_d;
  logic [7:0] press_q, press_d;
  logic       auto_q, auto_d;
  logic [1:0] mode_q, mode_d;

  logic [8:0] next_ticks;
  logic       do_sample;
  logic [1:0] code;
  logic       wrap;
  logic [7:0] press_inc;

  assign next_ticks = {1'b0, elapsed_q} + 9'd1;
  assign do_sample  = next_ticks > {1'b0, cfg_i.sample_interval};
  assign code       = {~key_two_raw_i, ~key_one_raw_i};
  assign wrap       = (scount_q > cfg_i.auto_period) || (scount_q == CountMax);
  assign press_inc  = (press_q == CountMax) ? press_q : press_q + 8'd1;

  always_comb begin
    elapsed_d = next_ticks[7:0];
    last_d    = last_q;
    deb_d     = deb_q;
    prev_d    = prev_q;
    scount_d  = scount_q;
    pflag_d   = pflag_q;
    press_d   = press_q;
    auto_d    = auto_q;
    mode_d    = mode_q;

    // Sampling step
    if (do_sample) begin
      elapsed_d = 8'd0;
      if (code == last_q) begin
        deb_d = code;
      end else begin
        last_d = code;
      end
      if (wrap) begin
        scount_d = 8'd1;
        pflag_d  = 1'b1;
      end else begin
        scount_d = scount_q + 8'd1;
      end
      if (press_q != 8'd0) begin
        if (deb_d[KeyOneBit]) begin
          press_d = press_inc;
          if (press_q <= cfg_i.long_press && press_inc > cfg_i.long_press) begin
            auto_d = ~auto_q;
          end
        end else begin
          press_d = 8'd0;
        end
      end
    end

    // Scan for a changed code, then for an automatic advance
    if (deb_d != prev_q) begin
      press_d = {7'd0, deb_d[KeyOneBit]};
      if (!auto_d && deb_d[KeyTwoBit]) begin
        mode_d = mode_q + 2'd1;
      end
      prev_d = deb_d;
    end
    if (auto_d && pflag_d) begin
      mode_d  = mode_d + 2'd1;
      pflag_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      last_q    <= '0;
      deb_q     <= '0;
      prev_q    <= '0;
      scount_q  <= '0;
      pflag_q   <= 1'b0;
      press_q   <= '0;
      auto_q    <= 1'b0;
      mode_q    <= '0;
    end else if (tick_i) begin
      elapsed_q <= elapsed_d;
      last_q    <= last_d;
      deb_q     <= deb_d;
      prev_q    <= prev_d;
      scount_q  <= scount_d;
      pflag_q   <= pflag_d;
      press_q   <= press_d;
      auto_q    <= auto_d;
      mode_q    <= mode_d;
    end
  end

  // Decode pins from the updated mode
  assign res_o.pin_a     = (mode_d != 2'd3);
  assign res_o.pin_b     = (mode_d == 2'd2);
  assign res_o.pin_c     = (mode_d == 2'd0) || (mode_d == 2'd3);
  assign res_o.wave_mode = mode_d;
  assign res_o.auto_on   = auto_d;

endmodule

// File: rtl/bwms_skid.sv
// ----------------------------------------------------------------------------
// bwms_skid
// Result register with one skid entry, so a request is taken while a
// finished result still waits.
// ----------------------------------------------------------------------------
module bwms_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bwms_pkg::result_t res_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bwms_pkg::result_t res_o
);
  import bwms_pkg::*;

  result_t out_q;
  result_t skid_q;
  logic    out_vld_q;
  logic    skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_vld_q && out_stall_i) begin
      if (push_i) begin
        skid_vld_q <= 1'b1;
      end
    end else if (skid_vld_q) begin
      out_vld_q  <= 1'b1;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_vld_q && out_stall_i) begin
      if (push_i) begin
        skid_q <= res_i;
      end
    end else if (skid_vld_q) begin
      out_q <= skid_q;
    end else if (push_i) begin
      out_q <= res_i;
    end
  end

  assign full_o      = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign res_o       = out_q;

  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held without a result in front");

  a_stalled_push_skids : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && out_vld_q && out_stall_i) |=> skid_vld_q)
    else $error("request taken under stall was not parked");

  a_skid_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && !out_stall_i) |=> (out_vld_q && out_q == $past(skid_q)))
    else $error("skid entry not moved to the result register");

endmodule

// File: rtl/button_wave_mode_selector_core.sv
// ----------------------------------------------------------------------------
// button_wave_mode_selector_core
// Debounced two-key wave mode selector with manual and automatic cycling.
// ----------------------------------------------------------------------------
// Each request is one millisecond tick carrying the raw active-low levels of
// both keys. The block takes one request per clock cycle while in_stall_o is
// low and delivers its result from the result register; the whole state update
// for a tick (sample, debounce, press timing, mode step) settles in
// combinational logic ahead of that register. A single skid entry behind the
// result register keeps input acceptance going for one more request while the
// downstream side stalls; in_stall_o rises only when that entry is occupied.
// Registers sit at byte addresses 0 (sample interval), 4 (auto period) and
// 8 (long press); write them only while no tick is in flight.
// ----------------------------------------------------------------------------
module button_wave_mode_selector_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tick requests
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           key_one_raw_i,
  input  logic                           key_two_raw_i,
  // results
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           pin_a_o,
  output logic                           pin_b_o,
  output logic                           pin_c_o,
  output logic [1:0]                     wave_mode_o,
  output logic                           auto_on_o,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bwms_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import bwms_pkg::*;

  cfg_t    cfg;
  result_t core_res;
  result_t out_res;
  logic    skid_full;
  logic    accept;

  // Take a request whenever the skid entry is free
  assign in_stall_o = skid_full;
  assign accept     = in_valid_i && !skid_full;

  bwms_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance the tick state only on an accepted request
  bwms_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .tick_i        (accept),
    .key_one_raw_i (key_one_raw_i),
    .key_two_raw_i (key_two_raw_i),
    .res_o         (core_res)
  );

  bwms_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .res_i       (core_res),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign pin_a_o     = out_res.pin_a;
  assign pin_b_o     = out_res.pin_b;
  assign pin_c_o     = out_res.pin_c;
  assign wave_mode_o = out_res.wave_mode;
  assign auto_on_o   = out_res.auto_on;

endmodule
